// ===== rtl/core/ose_pkg.sv =====
// Package for the ordered sequence store: sizes, codes and shared types.
package ose_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned ITEM_WIDTH = 32;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = 5;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ITEM_WIDTH-1:0] item_t;

  typedef enum logic [2:0] {
    ACT_INSERT_AT     = 3'd0,
    ACT_INSERT_SORTED = 3'd1,
    ACT_ERASE_AT      = 3'd2,
    ACT_REMOVE_ALL    = 3'd3,
    ACT_GET           = 3'd4,
    ACT_SET           = 3'd5,
    ACT_FIND          = 3'd6
  } act_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_SET
  } cell_op_e;

  typedef enum logic [1:0] {
    MARK_POS,
    MARK_GE,
    MARK_EQ
  } mark_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_e;

  typedef struct packed {
    cell_op_e         op;
    mark_e            mode;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] pos;
    item_t            key;
  } cell_ctrl_t;

  typedef struct packed {
    logic             any_first;
    logic [IDX_W-1:0] first_idx;
    item_t            rd_val;
  } row_stat_t;

endpackage

// ===== rtl/core/ose_cell.sv =====
// One storage cell of the sequence: holds an element, compares and shifts.
module ose_cell (
  input  logic                         clk_i,
  input  ose_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ose_pkg::IDX_W-1:0]    idx_i,
  input  ose_pkg::item_t               left_i,
  input  ose_pkg::item_t               right_i,
  input  logic                         mark_i,
  output ose_pkg::item_t               val_o,
  output logic                         mark_o,
  output logic                         first_o,
  output ose_pkg::item_t               rd_o
);

  ose_pkg::item_t val_q, val_d;
  logic           ge_q, eq_q;
  logic           in_range, sel, own_mark;

  assign in_range = ose_pkg::CNT_W'(idx_i) < ctrl_i.count;
  assign sel      = ose_pkg::CMP_W'(idx_i) == ose_pkg::CMP_W'(ctrl_i.pos);

  // The mark says this cell lies at or after the point of change; it is
  // handed down the row so that the first marked cell can be found.
  always_comb begin
    unique case (ctrl_i.mode)
      ose_pkg::MARK_POS: own_mark = ose_pkg::CMP_W'(idx_i) >= ose_pkg::CMP_W'(ctrl_i.pos);
      ose_pkg::MARK_GE:  own_mark = ge_q | ~in_range;
      ose_pkg::MARK_EQ:  own_mark = eq_q;
      default:           own_mark = 1'b0;
    endcase
  end

  assign mark_o  = own_mark | mark_i;
  assign first_o = own_mark & ~mark_i;
  assign val_o   = val_q;
  assign rd_o    = sel ? val_q : '0;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      ose_pkg::CELL_INS: begin
        if (mark_i) val_d = left_i;
        else if (own_mark) val_d = ctrl_i.key;
      end
      ose_pkg::CELL_DEL: begin
        if (mark_o) val_d = right_i;
      end
      ose_pkg::CELL_SET: begin
        if (sel) val_d = ctrl_i.key;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (ctrl_i.op == ose_pkg::CELL_CMP) begin
      ge_q <= in_range & (val_q >= ctrl_i.key);
      eq_q <= in_range & (val_q == ctrl_i.key);
    end
  end

endmodule

// ===== rtl/core/ose_ctrl.sv =====
// Sequencer of the sequence store: handshakes, element count and results.
module ose_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic [ose_pkg::POS_W-1:0]     position_i,
  input  logic [31:0]                   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic signed [5:0]             index_out_o,
  output logic [31:0]                   value_out_o,
  output logic [4:0]                    removed_count_o,
  output logic [4:0]                    count_out_o,
  input  ose_pkg::row_stat_t            stat_i,
  output ose_pkg::cell_ctrl_t           ctrl_o
);

  ose_pkg::state_e             state_q, state_d;
  ose_pkg::act_e               act_q;
  logic [ose_pkg::POS_W-1:0]   pos_q;
  ose_pkg::item_t              key_q;
  logic [ose_pkg::CNT_W-1:0]   count_q, count_d, rem_q, rem_d;
  logic                        out_valid_q, out_valid_d;
  logic                        ok_q, ok_d;
  logic signed [5:0]           idx_q, idx_d;
  logic [31:0]                 rdv_q, rdv_d;
  logic [4:0]                  remc_q, remc_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic                        accept, slot_free, full, pos_lt, pos_le;
  ose_pkg::cell_op_e           op;
  ose_pkg::mark_e              mode;

  assign accept    = in_valid_i & (state_q == ose_pkg::ST_IDLE);
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign full      = count_q == ose_pkg::CNT_W'(ose_pkg::CAPACITY);
  assign pos_lt    = ose_pkg::CMP_W'(pos_q) <  ose_pkg::CMP_W'(count_q);
  assign pos_le    = ose_pkg::CMP_W'(pos_q) <= ose_pkg::CMP_W'(count_q);

  always_comb begin
    unique case (act_q)
      ose_pkg::ACT_INSERT_SORTED: mode = ose_pkg::MARK_GE;
      ose_pkg::ACT_REMOVE_ALL,
      ose_pkg::ACT_FIND:          mode = ose_pkg::MARK_EQ;
      default:                    mode = ose_pkg::MARK_POS;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op          = ose_pkg::CELL_HOLD;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q & out_stall_i;
    ok_d        = ok_q;
    idx_d       = idx_q;
    rdv_d       = rdv_q;
    remc_d      = remc_q;
    cnt_d       = cnt_q;
    unique case (state_q)
      ose_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = ose_pkg::ST_CMP;
          rem_d   = '0;
        end
      end
      ose_pkg::ST_CMP: begin
        op      = ose_pkg::CELL_CMP;
        state_d = ose_pkg::ST_APPLY;
      end
      ose_pkg::ST_APPLY: begin
        if (act_q == ose_pkg::ACT_REMOVE_ALL && stat_i.any_first) begin
          // Drop the first match, then compare again.
          op      = ose_pkg::CELL_DEL;
          count_d = count_q - 1'b1;
          rem_d   = rem_q + 1'b1;
          state_d = ose_pkg::ST_CMP;
        end else if (slot_free) begin
          ok_d        = 1'b0;
          idx_d       = -6'sd1;
          rdv_d       = '0;
          remc_d      = '0;
          out_valid_d = 1'b1;
          state_d     = ose_pkg::ST_IDLE;
          unique case (act_q)
            ose_pkg::ACT_INSERT_AT: begin
              if (pos_le && !full) begin
                op      = ose_pkg::CELL_INS;
                count_d = count_q + 1'b1;
                ok_d    = 1'b1;
              end
            end
            ose_pkg::ACT_INSERT_SORTED: begin
              if (!full) begin
                op      = ose_pkg::CELL_INS;
                count_d = count_q + 1'b1;
                ok_d    = 1'b1;
                idx_d   = 6'(stat_i.first_idx);
              end
            end
            ose_pkg::ACT_ERASE_AT: begin
              if (pos_lt) begin
                op      = ose_pkg::CELL_DEL;
                count_d = count_q - 1'b1;
                ok_d    = 1'b1;
              end
            end
            ose_pkg::ACT_REMOVE_ALL: begin
              ok_d   = 1'b1;
              remc_d = 5'(rem_q);
            end
            ose_pkg::ACT_GET: begin
              if (pos_lt) begin
                ok_d  = 1'b1;
                rdv_d = 32'(stat_i.rd_val);
              end
            end
            ose_pkg::ACT_SET: begin
              if (pos_lt) begin
                op   = ose_pkg::CELL_SET;
                ok_d = 1'b1;
              end
            end
            ose_pkg::ACT_FIND: begin
              ok_d = 1'b1;
              if (stat_i.any_first) idx_d = 6'(stat_i.first_idx);
            end
            default: ok_d = 1'b0;
          endcase
          // The reported count is held with the result, since the next beat may
          // already change the live count while this result is stalled.
          cnt_d = 5'(count_d);
        end
      end
      default: state_d = ose_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ose_pkg::ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= ose_pkg::act_e'(action_i);
      pos_q <= position_i;
      key_q <= ose_pkg::item_t'(value_i);
    end
    ok_q   <= ok_d;
    idx_q  <= idx_d;
    rdv_q  <= rdv_d;
    remc_q <= remc_d;
    cnt_q  <= cnt_d;
  end

  assign ctrl_o.op    = op;
  assign ctrl_o.mode  = mode;
  assign ctrl_o.count = count_q;
  assign ctrl_o.pos   = pos_q;
  assign ctrl_o.key   = key_q;

  assign in_stall_o      = state_q != ose_pkg::ST_IDLE;
  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign index_out_o     = idx_q;
  assign value_out_o     = rdv_q;
  assign removed_count_o = remc_q;
  assign count_out_o     = cnt_q;

endmodule

// ===== rtl/core/ordered_sequence_store.sv =====
// Top level of the ordered sequence store: a row of element cells and a sequencer.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------------
//   in      | to block  | in_valid_i / in_stall_o    | action_i, position_i, value_i
//   out     | from block| out_valid_o / out_stall_i  | ok_o, index_out_o, value_out_o,
//           |           |                            | removed_count_o, count_out_o
//
// After a beat is accepted, all cells compare their element with the value in a compare state,
// and in the apply state that follows, the row shifts or is read and the result is registered.
// A remove-all returns to the compare state for each element it removes, one match dropped per pass.
// The block takes one beat at a time; the next beat is accepted in the cycle after the result
// is registered, even while that result is still stalled at the output.
// Reset clears the element count and the output valid; element storage needs no clearing.
// A stalled result holds its value; a finished operation waits until the output slot is free.
module ordered_sequence_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            action_i,
  input  logic [4:0]            position_i,
  input  logic [31:0]           value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic signed [5:0]     index_out_o,
  output logic [31:0]           value_out_o,
  output logic [4:0]            removed_count_o,
  output logic [4:0]            count_out_o
);

  localparam int unsigned N = ose_pkg::CAPACITY;

  ose_pkg::cell_ctrl_t ctrl;
  ose_pkg::row_stat_t  stat;
  ose_pkg::item_t      vals  [N];
  ose_pkg::item_t      rds   [N];
  logic [N:0]          marks;
  logic [N-1:0]        firsts;

  // The mark chain starts clear at the head of the row.
  assign marks[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    ose_pkg::item_t left_v, right_v;
    // The head cell never takes from the left and the tail never from the right.
    assign left_v  = (g == 0)     ? vals[g] : vals[(g == 0) ? 0 : g - 1];
    assign right_v = (g == N - 1) ? vals[g] : vals[(g == N - 1) ? g : g + 1];

    ose_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (ose_pkg::IDX_W'(g)),
      .left_i  (left_v),
      .right_i (right_v),
      .mark_i  (marks[g]),
      .val_o   (vals[g]),
      .mark_o  (marks[g+1]),
      .first_o (firsts[g]),
      .rd_o    (rds[g])
    );
  end

  // At most one cell reports the first mark and at most one is addressed, so plain OR
  // reductions gather the found index and the read element.
  always_comb begin
    stat.any_first = 1'b0;
    stat.first_idx = '0;
    stat.rd_val    = '0;
    for (int i = 0; i < N; i++) begin
      stat.any_first = stat.any_first | firsts[i];
      stat.first_idx = stat.first_idx | (firsts[i] ? ose_pkg::IDX_W'(i) : '0);
      stat.rd_val    = stat.rd_val | rds[i];
    end
  end

  ose_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .index_out_o     (index_out_o),
    .value_out_o     (value_out_o),
    .removed_count_o (removed_count_o),
    .count_out_o     (count_out_o),
    .stat_i          (stat),
    .ctrl_o          (ctrl)
  );

endmodule

// ===== sim/tb_ordered_sequence_store.sv =====
// Self-checking testbench for the ordered sequence store, with a shadow predictor and checker.
module tb_ordered_sequence_store;
  timeunit 1ns;
  timeprecision 1ps;

  import ose_pkg::*;

  // Action code 7 is not part of the operation set; the block must refuse it.
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // The limit is several times the slowest legal run: about 1560 beats, each with up to the
  // longest sender gap, a remove-all of a full store and a long output stall.
  localparam int CYCLE_LIMIT  = 600000;
  // This covers any late result, even one from a remove-all of a full store.
  localparam int DRAIN_CYCLES = 64;
  // Only the first mismatches are printed so that a broken block cannot flood the log.
  localparam int PRINT_LIMIT  = 40;

  // One expected result beat, field by field, at the widths of the output ports.
  typedef struct packed {
    logic               ok;
    logic signed [5:0]  idx;
    item_t              rd;
    logic [4:0]         removed;
    logic [4:0]         cnt;
  } reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        action_i;
  logic [4:0]        position_i;
  logic [31:0]       value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              ok_o;
  logic signed [5:0] index_out_o;
  logic [31:0]       value_out_o;
  logic [4:0]        removed_count_o;
  logic [4:0]        count_out_o;

  // Shadow copy of the sequence, updated as each beat is accepted.
  item_t       shadow_elems [CAPACITY];
  int unsigned shadow_count;

  // Results still owed by the block, oldest first.
  reply_t pending_replies [$];

  int mismatches;
  int beats_in;
  int replies_checked;
  int refused_inserts;
  int dropped_elems;
  int full_drains;
  int cycle_count;
  int burst_left;

  ordered_sequence_store DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .index_out_o     (index_out_o),
    .value_out_o     (value_out_o),
    .removed_count_o (removed_count_o),
    .count_out_o     (count_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The run is cut off if it ever exceeds the cycle budget.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_error(string msg);
    if (mismatches < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Makes room at a position by moving the later elements up by one, then writes the value.
  function automatic void open_slot(int unsigned at, item_t val);
    for (int unsigned k = shadow_count; k > at; k--) shadow_elems[k] = shadow_elems[k - 1];
    shadow_elems[at] = val;
    shadow_count++;
  endfunction

  // Applies one request to the shadow sequence and returns the result the block owes for it.
  function automatic reply_t apply_request(logic [2:0] op, logic [4:0] pos, item_t val);
    reply_t      r;
    int unsigned k;
    int unsigned keep;
    logic        hit;
    r.ok      = 1'b0;
    r.idx     = -6'sd1;
    r.rd      = '0;
    r.removed = '0;
    hit       = 1'b0;
    case (op)
      ACT_INSERT_AT: begin
        if (shadow_count == CAPACITY) refused_inserts++;
        if (pos <= shadow_count && shadow_count < CAPACITY) begin
          open_slot(pos, val);
          r.ok = 1'b1;
        end
      end
      ACT_INSERT_SORTED: begin
        if (shadow_count < CAPACITY) begin
          // Unsigned search for the first element that is not below the value.
          k = 0;
          while (k < shadow_count && shadow_elems[k] < val) k++;
          open_slot(k, val);
          r.idx = 6'(k);
          r.ok  = 1'b1;
        end else begin
          refused_inserts++;
        end
      end
      ACT_ERASE_AT: begin
        if (pos < shadow_count) begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_elems[k] = shadow_elems[k + 1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE_ALL: begin
        keep = 0;
        for (k = 0; k < shadow_count; k++) begin
          if (shadow_elems[k] != val) begin
            shadow_elems[keep] = shadow_elems[k];
            keep++;
          end
        end
        r.removed = 5'(shadow_count - keep);
        dropped_elems += shadow_count - keep;
        shadow_count = keep;
        r.ok = 1'b1;
      end
      ACT_GET: begin
        if (pos < shadow_count) begin
          r.rd = shadow_elems[pos];
          r.ok = 1'b1;
        end
      end
      ACT_SET: begin
        if (pos < shadow_count) begin
          shadow_elems[pos] = val;
          r.ok = 1'b1;
        end
      end
      ACT_FIND: begin
        for (k = 0; k < shadow_count; k++) begin
          if (!hit && shadow_elems[k] == val) begin
            r.idx = 6'(k);
            hit   = 1'b1;
          end
        end
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.cnt = 5'(shadow_count);
    return r;
  endfunction

  // Both handshakes are sampled at the rising edge. A result leaving the block is checked
  // before the beat entering in the same cycle is predicted, since the result is older.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        replies_checked++;
        if (pending_replies.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", replies_checked));
        end else begin
          want = pending_replies.pop_front();
          if (ok_o !== want.ok)
            report_error($sformatf("result %0d ok: got %0b, expected %0b",
                                   replies_checked, ok_o, want.ok));
          if (index_out_o !== want.idx)
            report_error($sformatf("result %0d index_out: got %0d, expected %0d",
                                   replies_checked, index_out_o, want.idx));
          if (value_out_o !== want.rd)
            report_error($sformatf("result %0d value_out: got %h, expected %h",
                                   replies_checked, value_out_o, want.rd));
          if (removed_count_o !== want.removed)
            report_error($sformatf("result %0d removed_count: got %0d, expected %0d",
                                   replies_checked, removed_count_o, want.removed));
          if (count_out_o !== want.cnt)
            report_error($sformatf("result %0d count_out: got %0d, expected %0d",
                                   replies_checked, count_out_o, want.cnt));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_replies.push_back(apply_request(action_i, position_i, value_i));
        beats_in++;
      end
    end
  end

  // The receiver stalls on its own schedule: stretches with no stall, light random stalls,
  // heavy stalls, and a toggling pattern, each for a random number of cycles.
  initial begin
    int mode;
    int span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i = 1'b0;
          1:       out_stall_i = ($urandom_range(0, 2) == 0);
          2:       out_stall_i = ($urandom_range(0, 7) < 6);
          default: out_stall_i = ~out_stall_i;
        endcase
      end
    end
  end

  // Holds the sender back until the block has returned every result it owes.
  task automatic wait_all_replies();
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    full_drains++;
  endtask

  // The sender works in bursts. Between bursts it idles for a few cycles, or now and then
  // until the block has nothing left in flight.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      if ($urandom_range(0, 39) == 0) wait_all_replies();
      else repeat ($urandom_range(1, 7)) @(negedge clk_i);
      burst_left = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(4, 30);
    end
  endtask

  // Presents one beat at the falling edge and holds it until the block takes it.
  task automatic send_request(logic [2:0] op, logic [4:0] pos, item_t val);
    action_i   = op;
    position_i = pos;
    value_i    = val;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    pace_sender();
  endtask

  // Values come mostly from a small pool so that duplicates, matches and ties are common.
  function automatic item_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return 32'h0000_0001;
        2:       return 32'h0000_0002;
        3:       return 32'h8000_0000;
        4:       return '1;
        default: return 32'h0000_00A5;
      endcase
    end
    if (sel < 7 && shadow_count > 0) return shadow_elems[$urandom_range(0, shadow_count - 1)];
    return $urandom();
  endfunction

  // Positions are mostly legal, with some just past the end and some anywhere in the field.
  function automatic logic [4:0] pick_pos(int unsigned top);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 5'($urandom_range(0, top));
    if (sel < 17) return 5'($urandom_range(0, CAPACITY));
    return 5'($urandom_range(0, 31));
  endfunction

  // Reads, writes, erases, finds and remove-all on an empty store, and the unused action code.
  task automatic test_empty_store();
    send_request(ACT_GET, 5'd0, '0);
    send_request(ACT_ERASE_AT, 5'd0, '0);
    send_request(ACT_SET, 5'd0, 32'h0000_0001);
    send_request(ACT_FIND, 5'd0, '0);
    send_request(ACT_REMOVE_ALL, 5'd0, '0);
    send_request(ACT_UNUSED, 5'd31, '1);
  endtask

  // Inserts past the end, at the front, end and middle, then reads and writes in range and past it.
  task automatic test_positional();
    send_request(ACT_INSERT_AT, 5'd1, 32'h0000_0011);
    send_request(ACT_INSERT_AT, 5'd0, '1);
    send_request(ACT_INSERT_AT, 5'd1, '0);
    send_request(ACT_INSERT_AT, 5'd1, 32'h8000_0000);
    send_request(ACT_INSERT_AT, 5'd0, 32'h0000_0055);
    send_request(ACT_GET, 5'd0, '0);
    send_request(ACT_GET, 5'(shadow_count - 1), '0);
    send_request(ACT_GET, 5'(shadow_count), '0);
    send_request(ACT_GET, 5'd31, '1);
    send_request(ACT_SET, 5'd2, 32'hA5A5_A5A5);
    send_request(ACT_SET, 5'(shadow_count), 32'h5A5A_5A5A);
  endtask

  // Find with and without a match, and sorted inserts at the front and before an equal value.
  task automatic test_search();
    send_request(ACT_FIND, 5'd0, '0);
    send_request(ACT_FIND, 5'd0, 32'h1234_5678);
    send_request(ACT_INSERT_SORTED, 5'd0, '0);
    send_request(ACT_INSERT_SORTED, 5'd31, '1);
  endtask

  // Remove-all with several matches and with none, then erase in the middle, last and past.
  task automatic test_erase_remove();
    send_request(ACT_REMOVE_ALL, 5'd0, '1);
    send_request(ACT_REMOVE_ALL, 5'd0, '1);
    send_request(ACT_ERASE_AT, 5'd1, '0);
    send_request(ACT_ERASE_AT, 5'(shadow_count - 1), '0);
    send_request(ACT_ERASE_AT, 5'(shadow_count), '0);
  endtask

  // Fills the store to capacity, shows that inserts are refused, then empties it again.
  // In the first round every added element holds the same value, so remove-all can drop many at once.
  task automatic test_full_store(int rounds);
    item_t val;
    for (int rnd = 0; rnd < rounds; rnd++) begin
      while (shadow_count < CAPACITY) begin
        val = (rnd == 0) ? 32'h0000_0042 : pick_value();
        if ($urandom_range(0, 1)) send_request(ACT_INSERT_AT, 5'($urandom_range(0, shadow_count)), val);
        else send_request(ACT_INSERT_SORTED, 5'($urandom()), val);
      end
      send_request(ACT_INSERT_AT, 5'(CAPACITY), pick_value());
      send_request(ACT_INSERT_AT, 5'($urandom_range(0, CAPACITY)), pick_value());
      send_request(ACT_INSERT_SORTED, 5'($urandom()), pick_value());
      repeat (3) begin
        send_request(ACT_GET, 5'($urandom_range(0, CAPACITY)), $urandom());
        send_request(ACT_FIND, 5'($urandom()), pick_value());
      end
      wait_all_replies();
      while (shadow_count > 0) begin
        if ($urandom_range(0, 2) == 0)
          send_request(ACT_ERASE_AT, 5'($urandom_range(0, shadow_count - 1)), $urandom());
        else
          send_request(ACT_REMOVE_ALL, 5'($urandom()),
                       shadow_elems[$urandom_range(0, shadow_count - 1)]);
      end
    end
  endtask

  // A weighted mix of all operations. Inserts outweigh removals, so the store spends
  // much of the time near or at capacity, where refusals and long compactions happen.
  task automatic test_random_mix(int beats);
    int          roll;
    int unsigned top;
    repeat (beats) begin
      roll = $urandom_range(0, 99);
      top  = (shadow_count > 0) ? shadow_count - 1 : 0;
      if (roll < 20)      send_request(ACT_INSERT_AT, pick_pos(shadow_count), pick_value());
      else if (roll < 35) send_request(ACT_INSERT_SORTED, 5'($urandom()), pick_value());
      else if (roll < 50) send_request(ACT_ERASE_AT, pick_pos(top), $urandom());
      else if (roll < 58) send_request(ACT_REMOVE_ALL, 5'($urandom()), pick_value());
      else if (roll < 70) send_request(ACT_GET, pick_pos(top), $urandom());
      else if (roll < 80) send_request(ACT_SET, pick_pos(top), pick_value());
      else if (roll < 97) send_request(ACT_FIND, 5'($urandom()), pick_value());
      else                send_request(ACT_UNUSED, 5'($urandom()), $urandom());
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_INSERT_AT;
    position_i   = '0;
    value_i      = '0;
    shadow_count = 0;
    burst_left   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_store();
    test_positional();
    test_search();
    test_erase_remove();
    test_full_store(4);
    test_random_mix(1380);

    // All beats are in; let the block return what it owes, then watch for stray results.
    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d beats sent and %0d results checked in %0d cycles.",
             beats_in, replies_checked, cycle_count);
    $display("Summary: %0d inserts refused when full, %0d elements dropped by remove-all.",
             refused_inserts, dropped_elems);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
